// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. Synthesis builds define
// SYNTH, which turns every macro into an empty body.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif

`endif

// File: rtl/core/ort_pkg.sv
// ---------------------------------------------------------------------------
// Operator run tokenizer package
// Shared constants, token and queue entry types, character classification.
// ---------------------------------------------------------------------------
`default_nettype none

package ort_pkg;

  // Character codes with a special role
  localparam logic [7:0] NewlineCode = 8'd10;
  localparam logic [7:0] ColonCode   = 8'd58;
  localparam logic [7:0] QuoteCode   = 8'd39;
  localparam logic [7:0] BslashCode  = 8'd92;
  localparam logic [7:0] SlashCode   = 8'd47;

  // Run length bound and widths
  localparam int unsigned MaxRun    = 256;
  localparam int unsigned RunW      = $clog2(MaxRun + 1);
  localparam int unsigned TokLenW   = 9;

  // Queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [TokLenW-1:0] len;
    logic               op;
    logic               eol;
  } ort_tok_t;

  // One queue entry holds the results of one input character
  typedef struct packed {
    logic     two;
    ort_tok_t tok0;
    ort_tok_t tok1;
  } ort_entry_t;

  // Operator and bracket characters: : + - * % ! & | < > = ~ , ^ # _ $ ? @ . ' / \ [ ] { } ( )
  function automatic logic is_op_char(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    unique case (c)
      8'd58, 8'd43, 8'd45, 8'd42, 8'd37, 8'd33, 8'd38, 8'd124, 8'd60, 8'd62,
      8'd61, 8'd126, 8'd44, 8'd94, 8'd35, 8'd95, 8'd36, 8'd63, 8'd64, 8'd46,
      8'd39, 8'd47, 8'd92, 8'd91, 8'd93, 8'd123, 8'd125, 8'd40, 8'd41: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Quote, backslash and slash wait for one character of lookahead
  function automatic logic is_prefix_char(input logic [7:0] c);
    return (c == QuoteCode) || (c == BslashCode) || (c == SlashCode);
  endfunction

  // Token length field keeps the low bits of the run count
  function automatic logic [TokLenW-1:0] run_to_len(input logic [RunW-1:0] r);
    logic [31:0] w;
    w = 32'(r);
    return w[TokLenW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ort_front.sv
// ---------------------------------------------------------------------------
// Tokenizer front end
// Classifies each character, tracks the held prefix and the pending run,
// and pushes the tokens that the character completes into the queue.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ort_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      char_code_i,
  input  wire logic            push_ready_i,
  output logic                 push_o,
  output ort_pkg::ort_entry_t  push_entry_o
);
  import ort_pkg::*;

  logic            prefix_q, prefix_d;
  logic [RunW-1:0] run_q, run_d;
  logic            accept;
  logic            c_nl, c_colon, c_pre, c_op, run_nz;
  logic [1:0]      n_res;
  ort_tok_t        tok0, tok1, op_tok, run_tok;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  // Classify the character
  assign c_nl    = (char_code_i == NewlineCode);
  assign c_colon = (char_code_i == ColonCode);
  assign c_pre   = is_prefix_char(char_code_i);
  assign c_op    = is_op_char(char_code_i);
  assign run_nz  = (run_q != '0);

  assign op_tok  = '{len: TokLenW'(1), op: 1'b1, eol: 1'b0};
  assign run_tok = '{len: run_to_len(run_q), op: 1'b0, eol: 1'b0};

  // Build the results and the next state
  always_comb begin
    tok0     = op_tok;
    tok1     = op_tok;
    n_res    = 2'd0;
    prefix_d = prefix_q;
    run_d    = run_q;
    if (prefix_q) begin
      prefix_d = 1'b0;
      n_res    = 2'd1;
      if (c_colon) begin
        tok0.len = TokLenW'(2);
      end else if (c_nl) begin
        tok0.eol = 1'b1;
      end else if (c_pre) begin
        prefix_d = 1'b1;
      end else if (c_op) begin
        n_res = 2'd2;
      end else if (run_q < RunW'(MaxRun)) begin
        run_d = run_q + RunW'(1);
      end
    end else begin
      priority if (c_nl) begin
        tok0     = run_tok;
        tok0.eol = 1'b1;
        n_res    = 2'd1;
        run_d    = '0;
      end else if (c_pre) begin
        tok0     = run_tok;
        n_res    = run_nz ? 2'd1 : 2'd0;
        run_d    = '0;
        prefix_d = 1'b1;
      end else if (c_op) begin
        if (run_nz) begin
          tok0  = run_tok;
          n_res = 2'd2;
        end else begin
          n_res = 2'd1;
        end
        run_d = '0;
      end else begin
        if (run_q < RunW'(MaxRun)) begin
          run_d = run_q + RunW'(1);
        end
      end
    end
  end

  assign push_o            = accept && (n_res != 2'd0);
  assign push_entry_o.two  = (n_res == 2'd2);
  assign push_entry_o.tok0 = tok0;
  assign push_entry_o.tok1 = tok1;

  // Advance state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= 1'b0;
      run_q    <= '0;
    end else if (accept) begin
      prefix_q <= prefix_d;
      run_q    <= run_d;
    end
  end

  `ASSERT_NEVER(a_prefix_with_run, clk_i, rst_ni, prefix_q && run_nz, "prefix held with run")
  `ASSERT_ALWAYS(a_run_bound, clk_i, rst_ni, run_q <= RunW'(MaxRun), "run count over bound")

endmodule

`default_nettype wire

// File: rtl/core/ort_fifo.sv
// ---------------------------------------------------------------------------
// Tokenizer queue
// Short flop queue of result entries between front and back end.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ort_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire ort_pkg::ort_entry_t  push_entry_i,
  output logic                      push_ready_o,
  input  wire logic                 pop_i,
  output logic                      head_valid_o,
  output ort_pkg::ort_entry_t       head_o
);
  import ort_pkg::*;

  ort_entry_t      mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(FifoDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(FifoDepth), "queue count overflow")
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && !push_ready_o, "push into full queue")

endmodule

`default_nettype wire

// File: rtl/core/ort_back.sv
// ---------------------------------------------------------------------------
// Tokenizer back end
// Takes queue entries apart into single tokens and drives the output
// register of the result channel.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ort_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 head_valid_i,
  input  wire ort_pkg::ort_entry_t  head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output ort_pkg::ort_tok_t         out_tok_o
);
  import ort_pkg::*;

  logic     out_valid_q, out_valid_d;
  ort_tok_t out_tok_q;
  logic     sel_q, sel_d;
  logic     load;
  ort_tok_t sel_tok;

  // Load a token when the output register is free or being drained
  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign sel_tok = sel_q ? head_i.tok1 : head_i.tok0;

  always_comb begin
    pop_o       = 1'b0;
    sel_d       = sel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      out_valid_d = 1'b1;
      if (head_i.two && !sel_q) begin
        sel_d = 1'b1;
      end else begin
        sel_d = 1'b0;
        pop_o = 1'b1;
      end
    end
  end

  // Hold the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_tok_q <= sel_tok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tok_o   = out_tok_q;

  `ASSERT_NEVER(a_sel_no_head, clk_i, rst_ni, sel_q && !head_valid_i, "second token without entry")
  `ASSERT_ALWAYS(a_sel_two, clk_i, rst_ni, !sel_q || head_i.two, "second token of single entry")

endmodule

`default_nettype wire

// File: rtl/core/operator_run_tokenizer.sv
// ---------------------------------------------------------------------------
// Operator run tokenizer
// Splits a character stream into tokens and reports each token's length.
// ---------------------------------------------------------------------------
// Input channel: one raw byte per transfer on char_code_i (in_valid_i /
// in_ready_o). Code 10 ends the line.
// Output channel: one token per transfer (out_valid_o / out_ready_i) with
// token_length_o, is_operator_o and end_of_line_o; the last token of a line
// carries end_of_line_o, a bare end of line has length 0.
// A result is pushed into the queue and then loaded into the output register.
// Throughput: one character per cycle while the queue has room; a
// character that completes two tokens takes two output transfers, as the
// single output register drains the four-entry queue between front and
// back end. Characters that complete no token (run members, held prefixes)
// take no output slot.
// Reset clears the held prefix, the pending run, the queue and the output.
// When the receiver stalls, the queue fills; in_ready_o drops only when all
// four entries are occupied.
// ---------------------------------------------------------------------------
`default_nettype none

module operator_run_tokenizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] char_code_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [8:0]      token_length_o,
  output logic            is_operator_o,
  output logic            end_of_line_o
);
  import ort_pkg::*;

  logic       push, push_ready, pop, head_valid;
  ort_entry_t push_entry, head;
  ort_tok_t   out_tok;

  ort_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .push_ready_i (push_ready),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  ort_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  ort_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_tok_o    (out_tok)
  );

  assign token_length_o = out_tok.len;
  assign is_operator_o  = out_tok.op;
  assign end_of_line_o  = out_tok.eol;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// Operator run tokenizer testbench
// Streams directed and random text lines through the tokenizer with random
// gaps on the input and random stalls on the output. A scoreboard predicts
// every token from the characters transferred and compares each token that
// comes out, in order, field by field.
// ---------------------------------------------------------------------------

module testbench;
  import ort_pkg::*;

  localparam int ItemTarget = 1750;
  localparam int HoldCycles = 80;
  localparam int IdleLimit  = 2000;
  localparam int DrainWait  = 8;
  localparam string OpChars = ":+-*%!&|<>=~,^#_$?@.'/\\[]{}()";

  // Predicts tokens from accepted characters and checks tokens that come out
  class token_scoreboard;
    ort_tok_t   pending_q[$];
    bit         prefix_held = 1'b0;
    logic [8:0] run_len     = '0;
    int errors       = 0;
    int checked      = 0;
    int op_tokens    = 0;
    int lines_ended  = 0;
    int clipped_chars = 0;

    function bit is_operator_char(logic [7:0] c);
      for (int i = 0; i < OpChars.len(); i++) begin
        if (OpChars[i] == c) return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit is_prefix(logic [7:0] c);
      return (c == QuoteCode) || (c == BslashCode) || (c == SlashCode);
    endfunction

    function void push_token(logic [8:0] len, bit op, bit eol);
      ort_tok_t t;
      t.len = len;
      t.op  = op;
      t.eol = eol;
      pending_q.push_back(t);
    endfunction

    // Report a pending ordinary run ahead of whatever ends it
    function void flush_run();
      if (run_len != 0) push_token(run_len, 1'b0, 1'b0);
      run_len = '0;
    endfunction

    function void note_char(logic [7:0] c);
      if (prefix_held) begin
        prefix_held = 1'b0;
        if (c == ColonCode) begin
          push_token(9'd2, 1'b1, 1'b0);
          return;
        end
        if (c == NewlineCode) begin
          push_token(9'd1, 1'b1, 1'b1);
          return;
        end
        push_token(9'd1, 1'b1, 1'b0);
      end
      if (c == NewlineCode) begin
        // A bare end of line carries length zero
        push_token(run_len, 1'b0, 1'b1);
        run_len = '0;
      end else if (is_prefix(c)) begin
        flush_run();
        prefix_held = 1'b1;
      end else if (is_operator_char(c)) begin
        flush_run();
        push_token(9'd1, 1'b1, 1'b0);
      end else if (int'(run_len) < MaxRun) begin
        run_len++;
      end else begin
        clipped_chars++;
      end
    endfunction

    function void check_token(logic [8:0] len, logic op, logic eol);
      ort_tok_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected token len=%0d op=%b eol=%b", $time, len, op, eol);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (len !== want.len) begin
        errors++;
        $display("%0t: token_length expected %0d actual %0d", $time, want.len, len);
      end
      if (op !== want.op) begin
        errors++;
        $display("%0t: is_operator expected %b actual %b", $time, want.op, op);
      end
      if (eol !== want.eol) begin
        errors++;
        $display("%0t: end_of_line expected %b actual %b", $time, want.eol, eol);
      end
      if (want.op) op_tokens++;
      if (want.eol) lines_ended++;
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] char_code_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [8:0] token_length_o;
  logic       is_operator_o;
  logic       end_of_line_o;

  token_scoreboard sb;
  int chars_sent   = 0;
  int stall_cycles = 0;
  bit tx_quiet     = 1'b0;
  bit rx_quiet     = 1'b0;
  bit rx_hold_req  = 1'b0;
  int long_runs_left = 3;

  operator_run_tokenizer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_length_o (token_length_o),
    .is_operator_o  (is_operator_o),
    .end_of_line_o  (end_of_line_o)
  );

  // Free-running clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == NewlineCode || sb.is_operator_char(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_op();
    return OpChars[$urandom_range(0, OpChars.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_prefix();
    case ($urandom_range(0, 2))
      0:       return QuoteCode;
      1:       return BslashCode;
      default: return SlashCode;
    endcase
  endfunction

  // Offer one character after a random gap; return at the falling edge
  // following its transfer with valid still high
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i);
    while (!in_ready_o);
    sb.note_char(c);
    chars_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering and hold until every predicted token has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i);
    while (sb.pending_q.size() != 0);
    @(negedge clk_i);
  endtask

  // Receiver holds off while a burst of operators fills the queue
  task automatic pressure_burst();
    rx_hold_req = 1'b1;
    tx_quiet    = 1'b1;
    repeat (40) send_char(pick_op());
    send_char(NewlineCode);
    wait_drained();
    tx_quiet = 1'b0;
  endtask

  // One line of mostly well-formed tokens with some raw noise
  task automatic send_line();
    int n_tok;
    int kind;
    int len;
    tx_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
    n_tok = $urandom_range(1, 10);
    repeat (n_tok) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        len = $urandom_range(1, 6);
        if (long_runs_left > 0 && $urandom_range(0, 49) == 0) begin
          long_runs_left--;
          len = MaxRun - 4 + $urandom_range(0, 40);
        end
        repeat (len) send_char(pick_plain());
      end else if (kind < 65) begin
        send_char(pick_op());
      end else if (kind < 80) begin
        send_char(pick_prefix());
        send_char(ColonCode);
      end else if (kind < 90) begin
        send_char(pick_prefix());
        send_char(8'($urandom_range(0, 255)));
      end else begin
        send_char(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) != 0) send_char(NewlineCode);
  endtask

  // Output side: random stalls, one long hold on request
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold_req) begin
        stall = HoldCycles;
        rx_hold_req = 1'b0;
      end else begin
        stall = rx_quiet ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i);
      while (!out_valid_o);
      sb.check_token(token_length_o, is_operator_o, end_of_line_o);
      @(negedge clk_i);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  initial begin
    int idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
      if (in_valid_i && !in_ready_o) stall_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    logic [7:0] directed_q[$];
    sb = new();
    directed_q = '{
      NewlineCode,
      8'h00, 8'h80, 8'hFF, 8'h7F, "+",
      QuoteCode, ColonCode, BslashCode, ColonCode, SlashCode, ColonCode,
      SlashCode, "q", SlashCode, QuoteCode, "(",
      "z", BslashCode, NewlineCode,
      "7", ")", "k", NewlineCode
    };
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    char_code_i = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed corner cases
    foreach (directed_q[i]) send_char(directed_q[i]);
    wait_drained();
    pressure_burst();

    // Random lines; a further pressure burst after each line ending near the halfway mark
    while (chars_sent < ItemTarget) begin
      send_line();
      if (chars_sent >= ItemTarget / 2 && chars_sent < ItemTarget / 2 + 20) begin
        wait_drained();
        pressure_burst();
      end
    end
    wait_drained();
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d characters; checked %0d tokens (%0d operator, %0d line ends).",
             chars_sent, sb.checked, sb.op_tokens, sb.lines_ended);
    $display("Input stalled %0d cycles; %0d characters past the run bound; %0d errors.",
             stall_cycles, sb.clipped_chars, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
